[hdl/ssm_pkg.sv]
// ----------------------------------------------------------------------------
// ssm_pkg
// shared types and constants for the streaming substring matcher
// ----------------------------------------------------------------------------
`default_nettype none

package ssm_pkg;

   localparam int CHAR_BITS      = 8;
   localparam int PATTERN_SLOTS  = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 64;
   localparam int LENGTH_BITS    = 5;
   localparam int POSITION_WIDTH = 16;

   typedef logic [CHAR_BITS-1:0] char_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PATTERN_LOW,
      CSR_PATTERN_HIGH,
      CSR_PATTERN_LENGTH
   } csr_index_type;

   typedef struct packed {
      logic                      found;
      logic [POSITION_WIDTH-1:0] position;
   } result_type;

endpackage

`default_nettype wire

[hdl/ssm_cell.sv]
// ----------------------------------------------------------------------------
// ssm_cell
// one window byte: holds it, hands it on, compares the incoming byte
// ----------------------------------------------------------------------------
`default_nettype none

module ssm_cell import ssm_pkg::*; #(
   parameter int INDEX       = 0,
   parameter int PATTERN_MAX = 16,
   parameter int LEN_BITS    = 5
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                shift,
   input  wire logic                clear,
   input  wire char_type            byte_in,
   input  wire char_type            pattern [PATTERN_MAX],
   input  wire logic [LEN_BITS-1:0] match_len,
   output      char_type            byte_out,
   output      logic                match
);

   char_type byte_ff;
   char_type byte_in_next;
   char_type want;

   // pattern byte that lines up with this cell: index match_len-1-INDEX
   always_comb begin
      want = '0;
      for (int j = 0; j < PATTERN_MAX; j++) begin
         if (int'(match_len) == j + INDEX + 1) begin
            want = pattern[j];
         end
      end
   end

   // cells past the pattern end always agree
   assign match = (int'(match_len) <= INDEX) || (byte_in == want);

   always_comb begin
      byte_in_next = byte_ff;
      if (clear) begin
         byte_in_next = '0;
      end else if (shift) begin
         byte_in_next = byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
      end else begin
         byte_ff <= byte_in_next;
      end
   end

   assign byte_out = byte_ff;

endmodule

`default_nettype wire

[hdl/ssm_rsp_buf.sv]
// ----------------------------------------------------------------------------
// ssm_rsp_buf
// output word register with one skid entry
// ----------------------------------------------------------------------------
`default_nettype none

module ssm_rsp_buf import ssm_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   input  wire result_type in_result,
   output      logic       out_valid,
   input  wire logic       out_stall,
   output      result_type out_result,
   output      logic       full
);

   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_result_ff;
   result_type out_result_in;
   logic       skid_valid_ff;
   logic       skid_valid_in;
   result_type skid_result_ff;
   result_type skid_result_in;
   logic       take;

   assign take = out_valid_ff & ~out_stall;

   always_comb begin
      out_valid_in   = out_valid_ff;
      out_result_in  = out_result_ff;
      skid_valid_in  = skid_valid_ff;
      skid_result_in = skid_result_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_result_in = skid_result_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_valid_ff || take) begin
            out_valid_in  = 1'b1;
            out_result_in = in_result;
         end else begin
            skid_valid_in  = 1'b1;
            skid_result_in = in_result;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_result_ff  <= out_result_in;
      skid_result_ff <= skid_result_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_result = out_result_ff;
   assign full       = skid_valid_ff;

endmodule

`default_nettype wire

[hdl/streaming_substring_matcher_core.sv]
// result words are registered for rsp_*; a skid entry takes one on stall
// throughput: one byte per cycle while req_stall is low; every window cell
// compares against the pattern in the accept cycle: the row sets the rate
// req_stall rises only when the output word and its skid entry are both full
// reset (synchronous, active high) clears pattern, window, count and flags
// ----------------------------------------------------------------------------
// streaming_substring_matcher_core
// first-match search of a configured byte pattern in a zero-terminated stream
// ----------------------------------------------------------------------------
`default_nettype none

module streaming_substring_matcher_core import ssm_pkg::*; #(
   parameter int PATTERN_MAX   = 16,
   parameter int POSITION_BITS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // byte stream in
   input  wire logic                      req_valid,
   output      logic                      req_stall,
   input  wire logic [CHAR_BITS-1:0]      req_ch,
   // result words out
   output      logic                      rsp_valid,
   input  wire logic                      rsp_stall,
   output      logic                      rsp_found,
   output      logic [POSITION_WIDTH-1:0] rsp_position,
   // register writes
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int LEN_BITS = $clog2(PATTERN_MAX + 1);
   localparam int EXT_BITS = (POSITION_BITS > POSITION_WIDTH) ? POSITION_BITS : POSITION_WIDTH;
   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
   localparam logic [EXT_BITS-1:0] OUT_MAX = EXT_BITS'({POSITION_WIDTH{1'b1}});

   // configuration registers
   logic [CSR_DATA_BITS-1:0] pattern_low_ff;
   logic [CSR_DATA_BITS-1:0] pattern_high_ff;
   logic [LENGTH_BITS-1:0]   pattern_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         pattern_length_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_PATTERN_LOW:    pattern_low_ff    <= csr_data;
            CSR_PATTERN_HIGH:   pattern_high_ff   <= csr_data;
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_data[LENGTH_BITS-1:0];
            default: ;
         endcase
      end
   end

   // pattern bytes, first character in slot 0
   char_type pattern_bytes [PATTERN_SLOTS];
   char_type cell_pattern  [PATTERN_MAX];

   always_comb begin
      for (int i = 0; i < PATTERN_SLOTS / 2; i++) begin
         pattern_bytes[i]                     = pattern_low_ff[i*CHAR_BITS +: CHAR_BITS];
         pattern_bytes[i + PATTERN_SLOTS / 2] = pattern_high_ff[i*CHAR_BITS +: CHAR_BITS];
      end
      for (int i = 0; i < PATTERN_MAX; i++) begin
         cell_pattern[i] = pattern_bytes[i];
      end
   end

   // effective length: clamp to the cell count, then stop at the first zero byte
   logic [LENGTH_BITS-1:0] length_clamped;
   logic [LEN_BITS-1:0]    eff_len;

   assign length_clamped = (pattern_length_ff > LENGTH_BITS'(PATTERN_MAX))
                           ? LENGTH_BITS'(PATTERN_MAX) : pattern_length_ff;

   always_comb begin
      eff_len = LEN_BITS'(length_clamped);
      for (int i = PATTERN_MAX - 1; i >= 0; i--) begin
         if ((i < int'(length_clamped)) && (cell_pattern[i] == '0)) begin
            eff_len = LEN_BITS'(i);
         end
      end
   end

   // string state
   logic [POSITION_BITS-1:0] count_ff;
   logic [POSITION_BITS-1:0] count_in;
   logic [POSITION_BITS-1:0] count_next;
   logic                     matched_ff;
   logic                     matched_in;

   logic       accept;
   logic       is_term;
   logic       len_zero;
   logic       shift;
   logic       clear;
   logic       hit;
   logic       res_valid;
   result_type res;
   logic       buf_full;
   result_type buf_result;

   assign accept   = req_valid & ~req_stall;
   assign is_term  = (req_ch == '0);
   assign len_zero = (eff_len == '0);

   // byte count after this byte, saturating
   assign count_next = (count_ff == POS_MAX) ? count_ff : count_ff + 1'b1;

   // window: cell 0 sees the incoming byte, cell k the byte held by cell k-1
   char_type                  link [PATTERN_MAX];
   logic [PATTERN_MAX-1:0]    cell_match;

   assign link[0] = req_ch;

   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      if (k < PATTERN_MAX - 1) begin : g_mid
         ssm_cell #(
            .INDEX       (k),
            .PATTERN_MAX (PATTERN_MAX),
            .LEN_BITS    (LEN_BITS)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift     (shift),
            .clear     (clear),
            .byte_in   (link[k]),
            .pattern   (cell_pattern),
            .match_len (eff_len),
            .byte_out  (link[k+1]),
            .match     (cell_match[k])
         );
      end else begin : g_last
         // oldest byte falls off the end of the row
         ssm_cell #(
            .INDEX       (k),
            .PATTERN_MAX (PATTERN_MAX),
            .LEN_BITS    (LEN_BITS)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift     (shift),
            .clear     (clear),
            .byte_in   (link[k]),
            .pattern   (cell_pattern),
            .match_len (eff_len),
            .byte_out  (),
            .match     (cell_match[k])
         );
      end
   end

   // full match needs enough bytes seen in this string
   assign hit = (&cell_match) && (count_next >= POSITION_BITS'(eff_len));

   // match start: saturated count wins, then clip to the output field
   logic [POSITION_BITS-1:0] pos_raw;
   logic [EXT_BITS-1:0]      pos_ext;
   logic [POSITION_WIDTH-1:0] pos_out;

   assign pos_raw = (count_ff == POS_MAX) ? POS_MAX
                    : count_ff + 1'b1 - POSITION_BITS'(eff_len);
   assign pos_ext = EXT_BITS'(pos_raw);
   assign pos_out = (pos_ext > OUT_MAX) ? POSITION_WIDTH'(OUT_MAX)
                    : pos_ext[POSITION_WIDTH-1:0];

   always_comb begin
      shift      = 1'b0;
      clear      = 1'b0;
      res_valid  = 1'b0;
      res        = '0;
      matched_in = matched_ff;
      count_in   = count_ff;
      if (accept) begin
         if (matched_ff) begin
            // already reported: just wait for the terminator
            clear = is_term;
         end else if (len_zero) begin
            // empty pattern hits at offset zero on the first byte
            res_valid = 1'b1;
            res.found = 1'b1;
            if (is_term) begin
               clear = 1'b1;
            end else begin
               matched_in = 1'b1;
            end
         end else if (is_term) begin
            // string ended with no match
            res_valid = 1'b1;
            clear     = 1'b1;
         end else begin
            shift    = 1'b1;
            count_in = count_next;
            if (hit) begin
               matched_in   = 1'b1;
               res_valid    = 1'b1;
               res.found    = 1'b1;
               res.position = pos_out;
            end
         end
      end
      if (clear) begin
         count_in   = '0;
         matched_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         matched_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         matched_ff <= matched_in;
      end
   end

   // result word register plus skid entry
   ssm_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (res_valid),
      .in_result  (res),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_result (buf_result),
      .full       (buf_full)
   );

   assign req_stall    = buf_full;
   assign rsp_found    = buf_result.found;
   assign rsp_position = buf_result.position;

   // skid entry only fills behind a waiting output word
   a_stall_has_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no output word pending");

   // at most one word per string
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !matched_ff)
      else $error("second result word in one string");

   // terminator always starts a fresh string
   a_term_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && is_term) |=> (count_ff == '0 && !matched_ff))
      else $error("string state not cleared after terminator");

endmodule

`default_nettype wire

[verif/ssm_match_checker.sv]
// ----------------------------------------------------------------------------
// ssm_match_checker
// watches the byte and result channels of the substring matcher, keeps its
// own copy of pattern and string state, and compares every result word
// ----------------------------------------------------------------------------

module ssm_match_checker import ssm_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic [CHAR_BITS-1:0]      req_ch,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic                      rsp_found,
   input  logic [POSITION_WIDTH-1:0] rsp_position,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output int                        words_outstanding,
   output int                        mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [POSITION_WIDTH-1:0] COUNT_CEILING = '1;

   logic [CSR_DATA_BITS-1:0]  pattern_lo;
   logic [CSR_DATA_BITS-1:0]  pattern_hi;
   logic [LENGTH_BITS-1:0]    pattern_len;
   char_type                  recent_bytes [PATTERN_SLOTS];
   logic [POSITION_WIDTH-1:0] bytes_in_string;
   bit                        string_matched;
   result_type                expected_words [$];
   int                        backlog  = 0;
   int                        failures = 0;

   assign words_outstanding = backlog;
   assign mismatch_count    = failures;

   function automatic char_type pattern_byte(int idx);
      logic [CSR_DATA_BITS-1:0] half;
      half = (idx < 8) ? pattern_lo : pattern_hi;
      return half[CHAR_BITS*(idx%8) +: CHAR_BITS];
   endfunction

   // pattern stops at its first zero byte, like a string
   function automatic int usable_length();
      int limit;
      int n;
      limit = (pattern_len > PATTERN_SLOTS) ? PATTERN_SLOTS : pattern_len;
      n = 0;
      while (n < limit && pattern_byte(n) != '0) n++;
      return n;
   endfunction

   task automatic forget_string();
      foreach (recent_bytes[i]) recent_bytes[i] = '0;
      bytes_in_string = '0;
      string_matched  = 1'b0;
   endtask

   task automatic expect_word(bit found, logic [POSITION_WIDTH-1:0] position);
      result_type w;
      w.found    = found;
      w.position = position;
      expected_words.push_back(w);
   endtask

   task automatic predict_byte(char_type c);
      int                        len;
      int                        start;
      bit                        hit;
      logic [POSITION_WIDTH-1:0] prior;
      len = usable_length();
      if (string_matched) begin
         if (c == '0) forget_string();
      end else if (len == 0) begin
         expect_word(1'b1, '0);
         if (c == '0) forget_string();
         else string_matched = 1'b1;
      end else if (c == '0) begin
         expect_word(1'b0, '0);
         forget_string();
      end else begin
         prior = bytes_in_string;
         for (int i = PATTERN_SLOTS - 1; i > 0; i--) recent_bytes[i] = recent_bytes[i-1];
         recent_bytes[0] = c;
         if (bytes_in_string != COUNT_CEILING) bytes_in_string++;
         if (bytes_in_string >= len) begin
            hit = 1'b1;
            for (int i = 0; i < len; i++) begin
               if (pattern_byte(i) != recent_bytes[len-1-i]) hit = 1'b0;
            end
            if (hit) begin
               string_matched = 1'b1;
               start = (prior == COUNT_CEILING) ? int'(COUNT_CEILING) : int'(prior) + 1 - len;
               expect_word(1'b1, start[POSITION_WIDTH-1:0]);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      result_type oldest;
      if (reset) begin
         pattern_lo  = '0;
         pattern_hi  = '0;
         pattern_len = '0;
         forget_string();
         expected_words.delete();
      end else begin
         // a word leaving now was caused by an earlier byte
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("result word with nothing expected: found=%0d position=%0d",
                      rsp_found, rsp_position);
               failures++;
            end else begin
               oldest = expected_words.pop_front();
               if (rsp_found !== oldest.found) begin
                  $error("found: expected %0d, got %0d", oldest.found, rsp_found);
                  failures++;
               end
               if (rsp_position !== oldest.position) begin
                  $error("position: expected %0d, got %0d", oldest.position, rsp_position);
                  failures++;
               end
            end
         end
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_PATTERN_LOW:    pattern_lo  = csr_data;
               CSR_PATTERN_HIGH:   pattern_hi  = csr_data;
               CSR_PATTERN_LENGTH: pattern_len = csr_data[LENGTH_BITS-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_byte(req_ch);
      end
      backlog <= expected_words.size();
   end

endmodule

[verif/tb_streaming_substring_matcher_core.sv]
// ----------------------------------------------------------------------------
// tb_streaming_substring_matcher_core
// drives byte strings and pattern register writes into the matcher under
// changing idle and stall patterns; a checker beside it predicts each word
// ----------------------------------------------------------------------------

module tb_streaming_substring_matcher_core;
   timeunit 1ns;
   timeprecision 1ps;
   import ssm_pkg::*;

   localparam int       HALF_PERIOD       = 10;
   localparam int       RESET_CYCLES      = 7;
   localparam int       RANDOM_BYTES      = 1300;
   localparam int       BYTES_PER_SETTING = 60;
   localparam int       LONG_HOLD_CYCLES  = 200;
   localparam int       SETTLE_CYCLES     = 4;
   localparam int       TIMEOUT_NS        = 2_000_000;
   localparam char_type TERMINATOR        = '0;
   localparam char_type LETTER_A          = 8'h61;

   logic                      clock            = 1'b0;
   logic                      reset            = 1'b1;
   logic                      req_valid        = 1'b0;
   char_type                  req_ch           = '0;
   logic                      rsp_stall        = 1'b0;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index        = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data         = '0;
   wire                       req_stall;
   wire                       rsp_valid;
   wire                       rsp_found;
   wire  [POSITION_WIDTH-1:0] rsp_position;
   int                        words_outstanding;
   int                        mismatch_count;

   // idle / stall odds in percent, changed per phase
   int send_idle_pct = 0;
   int stall_pct     = 0;
   // long receiver holds: stimulus asks, receiver process serves
   int holds_asked   = 0;
   int holds_done    = 0;
   int bytes_sent    = 0;

   // usable part of the current pattern, kept to build matching strings
   logic [2*CSR_DATA_BITS-1:0] needle_bits = '0;
   int                         needle_len  = 0;

   always #HALF_PERIOD clock = ~clock;

   streaming_substring_matcher_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_ch           (req_ch),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_position     (rsp_position),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   ssm_match_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_ch            (req_ch),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_found         (rsp_found),
      .rsp_position      (rsp_position),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .words_outstanding (words_outstanding),
      .mismatch_count    (mismatch_count)
   );

   // one byte word: random idle cycles first, then hold valid until accepted
   task automatic send_byte(char_type c);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch    <= c;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(char_type'(s[i]));
   endtask

   // first count bytes of the usable pattern
   task automatic send_needle(int count);
      for (int i = 0; i < count; i++) send_byte(needle_bits[CHAR_BITS*i +: CHAR_BITS]);
   endtask

   // filler leans on pattern bytes so partial matches happen often
   function automatic char_type fill_char();
      int slot;
      if (needle_len > 0 && $urandom_range(0, 3) != 0) begin
         slot = $urandom_range(0, needle_len - 1);
         return needle_bits[CHAR_BITS*slot +: CHAR_BITS];
      end
      if ($urandom_range(0, 1) == 1) return char_type'(LETTER_A + $urandom_range(0, 2));
      return char_type'($urandom_range(1, 255));
   endfunction

   task automatic send_fill(int count);
      repeat (count) send_byte(fill_char());
   endtask

   // stop offering bytes, wait for every expected word, then let
   // the pipeline run dry
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (words_outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // all three registers, back to back; only called with the block idle
   task automatic apply_pattern(logic [CSR_DATA_BITS-1:0] lo, logic [CSR_DATA_BITS-1:0] hi,
                                logic [LENGTH_BITS-1:0] len);
      int limit;
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_PATTERN_LOW;
      csr_data         <= lo;
      @(posedge clock);
      csr_index        <= CSR_PATTERN_HIGH;
      csr_data         <= hi;
      @(posedge clock);
      csr_index        <= CSR_PATTERN_LENGTH;
      csr_data         <= CSR_DATA_BITS'(len);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      // oversized length clamps, and the pattern ends at a zero byte
      needle_bits = {hi, lo};
      limit       = (len > PATTERN_SLOTS) ? PATTERN_SLOTS : len;
      needle_len  = 0;
      while (needle_len < limit && needle_bits[CHAR_BITS*needle_len +: CHAR_BITS] != '0)
         needle_len++;
   endtask

   // random setting: lengths mostly short, some empty, some above the
   // slot count; bytes from a small alphabet with the odd zero
   task automatic pick_pattern();
      logic [2*CSR_DATA_BITS-1:0] bytes;
      logic [LENGTH_BITS-1:0]     len;
      int                         pick;
      pick = $urandom_range(0, 99);
      if (pick < 10)      len = '0;
      else if (pick < 20) len = LENGTH_BITS'($urandom_range(PATTERN_SLOTS + 1, 31));
      else if (pick < 70) len = LENGTH_BITS'($urandom_range(1, 4));
      else                len = LENGTH_BITS'($urandom_range(5, PATTERN_SLOTS));
      for (int i = 0; i < PATTERN_SLOTS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 80)
            bytes[CHAR_BITS*i +: CHAR_BITS] = char_type'(LETTER_A + $urandom_range(0, 2));
         else if (pick < 95)
            bytes[CHAR_BITS*i +: CHAR_BITS] = char_type'($urandom_range(1, 255));
         else
            bytes[CHAR_BITS*i +: CHAR_BITS] = '0;
      end
      // now and then raw random words so every register bit moves
      if ($urandom_range(0, 9) == 0) bytes = {$urandom, $urandom, $urandom, $urandom};
      apply_pattern(bytes[CSR_DATA_BITS-1:0], bytes[2*CSR_DATA_BITS-1:CSR_DATA_BITS], len);
   endtask

   // mostly filler + pattern (sometimes cut short) + filler, some raw noise,
   // some empty strings; every string ends with a terminator
   task automatic send_random_string();
      int shape;
      int cut;
      shape = $urandom_range(0, 99);
      if (shape < 70) begin
         send_fill($urandom_range(0, 10));
         cut = ($urandom_range(0, 3) == 0) ? $urandom_range(0, needle_len) : needle_len;
         send_needle(cut);
         send_fill($urandom_range(0, 6));
      end else if (shape < 92) begin
         repeat ($urandom_range(1, 24)) send_byte(char_type'($urandom_range(1, 255)));
      end
      send_byte(TERMINATOR);
   endtask

   // receiver: random stalls, or a long hold when the stimulus asks for one
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (holds_done != holds_asked) begin
            holds_done++;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   initial begin : stimulus
      int phase;
      int phase_start;
      int setting_start;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers at reset value: empty pattern, so a lone terminator
      // matches at 0, and so does the first byte of the next string
      send_byte(TERMINATOR);
      send_text("ab");
      send_byte(TERMINATOR);
      settle();

      // plain two-byte pattern: hit at offset 1, a miss, an empty string
      apply_pattern(64'h6261, '0, 2);
      send_text("xab");
      send_byte(TERMINATOR);
      send_text("a");
      send_byte(TERMINATOR);
      send_byte(TERMINATOR);
      settle();

      // all-ones registers at full length, then length clamped from 31
      apply_pattern('1, '1, PATTERN_SLOTS);
      send_needle(PATTERN_SLOTS);
      send_byte(TERMINATOR);
      settle();
      apply_pattern('1, '1, '1);
      send_text("b");
      send_needle(PATTERN_SLOTS);
      send_byte(TERMINATOR);
      settle();

      // full-width pattern spanning both registers, one-hot bytes low and
      // one-cold bytes high, then the same string with its last byte wrong
      apply_pattern(64'h0102_0408_1020_4080, 64'hfefd_fbf7_efdf_bf7f, PATTERN_SLOTS);
      send_text("q");
      send_needle(PATTERN_SLOTS);
      send_byte(TERMINATOR);
      send_needle(PATTERN_SLOTS - 1);
      send_text("q");
      send_byte(TERMINATOR);
      settle();

      // zero byte inside the pattern cuts it to one character
      apply_pattern(64'h62_00_61, '0, 3);
      send_text("ba");
      send_byte(TERMINATOR);
      settle();

      // zero as first pattern byte behaves as an empty pattern
      apply_pattern(64'h61_00, '0, 5);
      send_text("q");
      send_byte(TERMINATOR);
      send_byte(TERMINATOR);
      settle();

      // pattern changed in the middle of a string: bytes already in the
      // window are compared against the new pattern
      apply_pattern(64'h7a7a, '0, 2);
      send_text("abc");
      settle();
      apply_pattern(64'h646362, '0, 3);
      send_text("d");
      send_byte(TERMINATOR);
      settle();

      // long receiver hold with the byte side running flat out: every
      // two-byte string yields a word, so the output backs up into req_stall
      apply_pattern('0, '0, '0);
      holds_asked++;
      repeat (30) begin
         send_byte(8'h5a);
         send_byte(TERMINATOR);
      end
      settle();

      // random part, one idling scheme per phase, new pattern every few
      // dozen bytes; sometimes a string is left open across the rewrite
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 63;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 63;
            end
            default: begin
               send_idle_pct = 7;
               stall_pct     = 7;
            end
         endcase
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < RANDOM_BYTES / 4) begin
            pick_pattern();
            setting_start = bytes_sent;
            while (bytes_sent - setting_start < BYTES_PER_SETTING) send_random_string();
            if ($urandom_range(0, 2) == 0) send_fill($urandom_range(1, 6));
            settle();
         end
      end

      // close any open string and drain
      send_byte(TERMINATOR);
      settle();

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #TIMEOUT_NS;
      $display("FAIL");
      $finish;
   end

endmodule
